// ----- src/vdft_pkg.sv -----
// Shared constants, the point table entry layout and the controller state type
// for the vertex dedup / fan triangulation block. No dependencies.
`default_nettype none

package vdft_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int PTR_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = PTR_BITS + 1;
    localparam int ATTR_BITS   = 16;
    localparam int OUT_BITS    = 11;

    // One unique corner as stored in the point table.
    typedef struct packed {
        logic [ATTR_BITS-1:0] vertex;
        logic                 has_tex;
        logic [ATTR_BITS-1:0] tex;
        logic                 has_normal;
        logic [ATTR_BITS-1:0] normal;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- src/vdft_point_ram.sv -----
// Point table storage: one write port, one read port with registered read data.
// Depends on vdft_pkg.
`default_nettype none

module vdft_point_ram (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [vdft_pkg::PTR_BITS-1:0] wr_addr,
    input  wire vdft_pkg::entry_t            wr_data,
    input  wire logic                        rd_en,
    input  wire logic [vdft_pkg::PTR_BITS-1:0] rd_addr,
    output vdft_pkg::entry_t                 rd_data_reg
);

    vdft_pkg::entry_t mem [vdft_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/vertex_dedup_fan_triangulator.sv -----
// Top level of the vertex dedup / fan triangulation block: search controller,
// face state and result register. Depends on vdft_pkg and vdft_point_ram.
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready   | mode, face_start, vertex/tex/normal index
//   m_       | out       | m_valid / m_ready   | point index, new/full flags, triangle
//
// A corner goes through the scan and finish states to the output register. The scan
// reads the N points stored at that time (N is 0 to 2048) unless a hit at entry k ends
// it early. The point table memory is read one entry per cycle, so the linear search
// sets how long a corner takes. A clear skips the scan and goes to the finish state.
// s_ready returns in the cycle after the result is written. Reset empties the table by
// zeroing the point count; no memory sweep is needed. A result held by m_ready low
// does not block the next input transfer, but the controller waits in its finish state
// until the output register is free.
`default_nettype none

module vertex_dedup_fan_triangulator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic                          s_face_start,
    input  wire logic [vdft_pkg::ATTR_BITS-1:0] s_vertex_index,
    input  wire logic                          s_has_tex,
    input  wire logic [vdft_pkg::ATTR_BITS-1:0] s_tex_index,
    input  wire logic                          s_has_normal,
    input  wire logic [vdft_pkg::ATTR_BITS-1:0] s_normal_index,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vdft_pkg::OUT_BITS-1:0]      m_point_index,
    output logic                               m_point_new,
    output logic                               m_table_full,
    output logic                               m_tri_valid,
    output logic [vdft_pkg::OUT_BITS-1:0]      m_tri_first,
    output logic [vdft_pkg::OUT_BITS-1:0]      m_tri_previous
);

    localparam int PB = vdft_pkg::PTR_BITS;
    localparam int CB = vdft_pkg::CNT_BITS;

    vdft_pkg::state_t state_reg, state_next;

    // Captured request.
    vdft_pkg::entry_t key_reg;
    logic             clear_reg;
    logic             face_start_reg;

    // Scan pipeline: issue stage drives the memory address, compare stage sees data.
    logic [CB-1:0] issue_addr_reg;
    logic          cmp_valid_reg;
    logic [PB-1:0] cmp_addr_reg;
    logic          found_reg;
    logic [PB-1:0] found_idx_reg;

    // Table fill and face state.
    logic [CB-1:0] point_count_reg;
    logic [1:0]    corner_count_reg;
    logic [PB-1:0] origin_reg;
    logic [PB-1:0] previous_reg;

    // Result register.
    logic          m_valid_reg;
    logic [PB-1:0] m_point_index_reg;
    logic          m_point_new_reg;
    logic          m_table_full_reg;
    logic          m_tri_valid_reg;
    logic [PB-1:0] m_tri_first_reg;
    logic [PB-1:0] m_tri_previous_reg;

    vdft_pkg::entry_t s_key;
    vdft_pkg::entry_t rd_data;
    logic             s_accept;
    logic             issue_active;
    logic             hit;
    logic             scan_end;
    logic             out_free;
    logic             finish;
    logic             table_is_full;
    logic             append;
    logic [1:0]       fan_cc;
    logic [PB-1:0]    res_idx;

    // Absent optional indices are stored as zero so that absent only matches absent.
    always_comb begin
        s_key.vertex     = s_vertex_index;
        s_key.has_tex    = s_has_tex;
        s_key.tex        = s_has_tex ? s_tex_index : '0;
        s_key.has_normal = s_has_normal;
        s_key.normal     = s_has_normal ? s_normal_index : '0;
    end

    assign s_ready  = (state_reg == vdft_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // The scan stops at the first matching entry, which gives insertion order.
    assign hit          = (state_reg == vdft_pkg::ST_SCAN) && cmp_valid_reg && (rd_data == key_reg);
    assign issue_active = (state_reg == vdft_pkg::ST_SCAN) && !hit &&
                          (issue_addr_reg < point_count_reg);
    // With nothing in flight and every stored entry issued, the triple is new.
    assign scan_end     = hit || ((state_reg == vdft_pkg::ST_SCAN) && !cmp_valid_reg &&
                          (issue_addr_reg >= point_count_reg));

    assign finish        = (state_reg == vdft_pkg::ST_FINISH) && out_free;
    assign table_is_full = point_count_reg[PB];
    assign append        = !clear_reg && !found_reg && !table_is_full;
    assign fan_cc        = face_start_reg ? 2'd0 : corner_count_reg;
    assign res_idx       = found_reg ? found_idx_reg : point_count_reg[PB-1:0];

    vdft_point_ram u_ram (
        .aclk        (aclk),
        .wr_en       (finish && append),
        .wr_addr     (point_count_reg[PB-1:0]),
        .wr_data     (key_reg),
        .rd_en       (issue_active),
        .rd_addr     (issue_addr_reg[PB-1:0]),
        .rd_data_reg (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vdft_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_mode ? vdft_pkg::ST_FINISH : vdft_pkg::ST_SCAN;
                end
            end
            vdft_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = vdft_pkg::ST_FINISH;
                end
            end
            vdft_pkg::ST_FINISH: begin
                if (finish) begin
                    state_next = vdft_pkg::ST_IDLE;
                end
            end
            default: state_next = vdft_pkg::ST_IDLE;
        endcase
    end

    // Request capture and scan pipeline.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg        <= s_key;
            clear_reg      <= s_mode;
            face_start_reg <= s_face_start;
            issue_addr_reg <= '0;
            found_reg      <= 1'b0;
        end else begin
            if (issue_active) begin
                issue_addr_reg <= issue_addr_reg + CB'(1);
            end
            if (hit) begin
                found_reg     <= 1'b1;
                found_idx_reg <= cmp_addr_reg;
            end
        end
        cmp_addr_reg <= issue_addr_reg[PB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= issue_active;
        end
    end

    // Table fill count and face state are updated when the result is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg  <= '0;
            corner_count_reg <= '0;
            origin_reg       <= '0;
            previous_reg     <= '0;
        end else if (finish) begin
            if (clear_reg) begin
                point_count_reg  <= '0;
                corner_count_reg <= '0;
                origin_reg       <= '0;
                previous_reg     <= '0;
            end else if (!found_reg && table_is_full) begin
                // Dropped corner: only a face start has an effect.
                corner_count_reg <= fan_cc;
            end else begin
                if (append) begin
                    point_count_reg <= point_count_reg + CB'(1);
                end
                if (fan_cc == 2'd0) begin
                    origin_reg <= res_idx;
                end
                previous_reg     <= res_idx;
                corner_count_reg <= fan_cc[1] ? fan_cc : fan_cc + 2'd1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_point_index_reg  <= '0;
            m_point_new_reg    <= 1'b0;
            m_table_full_reg   <= 1'b0;
            m_tri_valid_reg    <= 1'b0;
            m_tri_first_reg    <= '0;
            m_tri_previous_reg <= '0;
            if (!clear_reg) begin
                if (!found_reg && table_is_full) begin
                    m_table_full_reg <= 1'b1;
                end else begin
                    m_point_index_reg <= res_idx;
                    m_point_new_reg   <= !found_reg;
                    if (fan_cc[1]) begin
                        m_tri_valid_reg    <= 1'b1;
                        m_tri_first_reg    <= origin_reg;
                        m_tri_previous_reg <= previous_reg;
                    end
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_index  = m_point_index_reg;
    assign m_point_new    = m_point_new_reg;
    assign m_table_full   = m_table_full_reg;
    assign m_tri_valid    = m_tri_valid_reg;
    assign m_tri_first    = m_tri_first_reg;
    assign m_tri_previous = m_tri_previous_reg;

endmodule

`default_nettype wire

// ----- src/vdft_checker.sv -----
// Port-level checks for the vertex dedup / fan triangulation block and the bind
// that attaches them to its top level. Depends on vdft_pkg.
`default_nettype none

module vdft_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [vdft_pkg::OUT_BITS-1:0] m_point_index,
    input wire logic                          m_point_new,
    input wire logic                          m_table_full,
    input wire logic                          m_tri_valid,
    input wire logic [vdft_pkg::OUT_BITS-1:0] m_tri_first,
    input wire logic [vdft_pkg::OUT_BITS-1:0] m_tri_previous
);

    // A stalled result keeps its valid, its point index and its triangle flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_index) && $stable(m_tri_valid))
        else $error("result changed while stalled");

    // A dropped corner carries no point and no triangle.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> m_point_index == '0 && !m_point_new && !m_tri_valid)
        else $error("dropped corner carries data");

    // Triangle fields are zero unless a triangle is emitted.
    a_tri: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tri_valid |-> m_tri_first == '0 && m_tri_previous == '0)
        else $error("triangle fields set without triangle");

    // One corner at a time: s_ready is low in the cycle after an input transfer.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous corner in work");

endmodule

bind vertex_dedup_fan_triangulator vdft_checker u_vdft_checker (.*);

`default_nettype wire
